// ----- design/hcbd_pkg.sv -----
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; every other design file imports this package.
package hcbd_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.hit   = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = 4'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            h.value = 4'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            h.value = 4'(c - 8'h57);
        end
        else begin
            h.hit = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- design/hcbd_if.sv -----
// Request channels of the chunked body decoder: raw body bytes in, results out.
// Depends on hcbd_pkg.
interface hcbd_body_if;
    import hcbd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, in_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, in_byte, first_byte, last_byte, output ready);
endinterface

interface hcbd_result_if;
    import hcbd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;

    modport source (output valid, out_byte, out_valid, status, input ready);
    modport sink   (input valid, out_byte, out_valid, status, output ready);
endinterface

// ----- design/http_chunked_body_decoder.sv -----
// HTTP/1.1 chunked body decoder: takes one body byte per cycle while body.ready is high and
// returns one registered result per byte. Each result carries the byte when it is
// payload (out_valid), and a status of in progress, complete, or error (sticky until a
// request with first_byte restarts the parser). Payload streams out before the chunk's
// trailing CRLF is checked, so drop payload from any message that ends in error status.
// Throughput is one byte per clock while body.ready is high; a two-entry result buffer keeps
// body.ready registered and holds one extra result under result backpressure.
// Depends on hcbd_pkg, hcbd_if, hcbd_parser and hcbd_out_buf.
module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    hcbd_body_if.sink            body,
    hcbd_result_if.source        result
);

    req_t req;
    res_t res;
    res_t res_q;
    logic accept;

    assign req.in_byte    = body.in_byte;
    assign req.first_byte = body.first_byte;
    assign req.last_byte  = body.last_byte;
    assign accept         = body.valid && body.ready;

    hcbd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .req     (req),
        .res     (res)
    );

    hcbd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (body.valid),
        .push_ready (body.ready),
        .push_res   (res),
        .pop_valid  (result.valid),
        .pop_ready  (result.ready),
        .pop_res    (res_q)
    );

    assign result.out_byte  = res_q.out_byte;
    assign result.out_valid = res_q.out_valid;
    assign result.status    = res_q.status;

endmodule

// ----- design/hcbd_parser.sv -----
// Chunked framing parser: phase and count registers plus the per-byte decode.
// Depends on hcbd_pkg.
module hcbd_parser
    import hcbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  req_t req,
    output res_t res
);

    localparam logic [3:0] PH_SIZE_FIRST = 4'd0;
    localparam logic [3:0] PH_SIZE_MORE  = 4'd1;
    localparam logic [3:0] PH_SIZE_LF    = 4'd2;
    localparam logic [3:0] PH_EXT        = 4'd3;
    localparam logic [3:0] PH_EXT_LF     = 4'd4;
    localparam logic [3:0] PH_DATA       = 4'd5;
    localparam logic [3:0] PH_DATA_CR    = 4'd6;
    localparam logic [3:0] PH_DATA_LF    = 4'd7;
    localparam logic [3:0] PH_DONE       = 4'd8;
    localparam logic [3:0] PH_ERR        = 4'd9;

    logic [3:0]            phase_reg;
    logic [3:0]            phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [3:0]            cur_phase;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  data_hit;
    logic [3:0]            size_done_phase;
    hex_t                  hex;

    always_comb
    begin
        cur_phase       = req.first_byte ? PH_SIZE_FIRST : phase_reg;
        cur_count       = req.first_byte ? '0 : count_reg;
        hex             = hex_decode(req.in_byte);
        size_done_phase = (cur_count == '0) ? PH_DONE : PH_DATA;
        phase_next      = cur_phase;
        count_next      = cur_count;
        data_hit        = 1'b0;
        case (cur_phase)
            PH_SIZE_FIRST:
            begin
                if (hex.hit)
                begin
                    count_next = COUNT_BITS'(hex.value);
                    phase_next = PH_SIZE_MORE;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_SIZE_MORE:
            begin
                if (hex.hit)
                begin
                    if (cur_count[COUNT_BITS-1 -: 4] != 4'd0)
                    begin
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        count_next = {cur_count[COUNT_BITS-5:0], hex.value};
                    end
                end
                else if (req.in_byte == CH_SEMI)
                begin
                    phase_next = PH_EXT;
                end
                else if (req.in_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else
                begin
                    phase_next = PH_ERR;
                end
            end
            PH_SIZE_LF:
            begin
                phase_next = (req.in_byte == CH_LF) ? size_done_phase : PH_ERR;
            end
            PH_EXT:
            begin
                if (req.in_byte == CH_CR)
                begin
                    phase_next = PH_EXT_LF;
                end
            end
            PH_EXT_LF:
            begin
                if (req.in_byte == CH_LF)
                begin
                    phase_next = size_done_phase;
                end
                else if (req.in_byte != CH_CR)
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_DATA:
            begin
                data_hit   = 1'b1;
                count_next = cur_count - COUNT_BITS'(1);
                if (cur_count == COUNT_BITS'(1))
                begin
                    phase_next = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
            begin
                phase_next = (req.in_byte == CH_CR) ? PH_DATA_LF : PH_ERR;
            end
            PH_DATA_LF:
            begin
                phase_next = (req.in_byte == CH_LF) ? PH_SIZE_FIRST : PH_ERR;
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase

        if (req.last_byte && (phase_next != PH_DONE))
        begin
            phase_next = PH_ERR;
        end

        res.out_byte  = data_hit ? req.in_byte : 8'd0;
        res.out_valid = data_hit;
        if (phase_next == PH_DONE)
        begin
            res.status = ST_DONE;
        end
        else if (phase_next == PH_ERR)
        begin
            res.status = ST_ERR;
        end
        else
        begin
            res.status = ST_BUSY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE_FIRST;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/hcbd_out_buf.sv -----
// Two-entry result register: a main stage plus a skid stage so input ready is registered.
// Depends on hcbd_pkg.
module hcbd_out_buf
    import hcbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  res_t push_res,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_res
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic push;
    logic pop;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_res    = main_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            if (push)
            begin
                main_reg <= push_res;
            end
        end
        else if (push)
        begin
            skid_reg <= push_res;
        end
    end

endmodule

// ----- design/hcbd_checker.sv -----
// Port-level checks for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder.
module hcbd_checker
    import hcbd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] out_byte,
    input logic       out_valid,
    input logic [1:0] status
);

    logic [1:0] held_reg;
    logic [1:0] held_next;

    always_comb
    begin
        held_next = held_reg;
        if ((in_valid && in_ready) && !(res_valid && res_ready))
        begin
            held_next = held_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && (res_valid && res_ready))
        begin
            held_next = held_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_buffer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready |-> held_reg == 2'd2) and ((held_reg == 2'd0) |-> !res_valid))
        else $error("ready or valid out of step with buffer occupancy");

    a_no_data_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status != ST_DONE)
        else $error("payload byte reported with complete status");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_byte == 8'd0)
        else $error("non-payload result carries a byte");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (body.valid),
    .in_ready  (body.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .out_byte  (result.out_byte),
    .out_valid (result.out_valid),
    .status    (result.status)
);

// ----- verif/hcbd_decode_checker.sv -----
`timescale 1ns / 100ps
// Checker for the chunked body decoder: watches the body and result channels, predicts
// each result from the accepted body bytes and compares it field by field.
// Depends on hcbd_pkg and the channel interfaces in hcbd_if.
module hcbd_decode_checker
    import hcbd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    hcbd_body_if   body,
    hcbd_result_if result,
    output int     fail_count,
    output int     expected_left
);

    localparam logic [4:0] HEX_RADIX = 5'd16;

    typedef enum logic [3:0] {
        P_SIZE_FIRST,
        P_SIZE_MORE,
        P_SIZE_LF,
        P_EXT,
        P_EXT_LF,
        P_DATA,
        P_DATA_CR,
        P_DATA_LF,
        P_DONE,
        P_ERR
    } parse_phase_e;

    parse_phase_e          phase_q    = P_SIZE_FIRST;
    logic [COUNT_BITS-1:0] chunk_left = '0;
    res_t                  decoded_q[$];
    int                    errors     = 0;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, 4'(c - 8'h30)};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return HEX_RADIX;
    endfunction

    function automatic res_t decode_byte(input req_t r);
        res_t       o;
        logic [4:0] d;
        o = '0;
        d = digit_of(r.in_byte);
        if (r.first_byte) begin
            phase_q    = P_SIZE_FIRST;
            chunk_left = '0;
        end
        case (phase_q)
            P_SIZE_FIRST:
            begin
                if (d < HEX_RADIX) begin
                    chunk_left = COUNT_BITS'(d[3:0]);
                    phase_q    = P_SIZE_MORE;
                end
                else begin
                    phase_q = P_ERR;
                end
            end
            P_SIZE_MORE:
            begin
                if (d < HEX_RADIX) begin
                    if (chunk_left[COUNT_BITS-1 -: 4] != 4'd0) begin
                        phase_q = P_ERR;
                    end
                    else begin
                        chunk_left = {chunk_left[COUNT_BITS-5:0], d[3:0]};
                    end
                end
                else if (r.in_byte == CH_SEMI) begin
                    phase_q = P_EXT;
                end
                else if (r.in_byte == CH_CR) begin
                    phase_q = P_SIZE_LF;
                end
                else begin
                    phase_q = P_ERR;
                end
            end
            P_SIZE_LF:
            begin
                if (r.in_byte == CH_LF) begin
                    phase_q = (chunk_left == '0) ? P_DONE : P_DATA;
                end
                else begin
                    phase_q = P_ERR;
                end
            end
            P_EXT:
            begin
                if (r.in_byte == CH_CR) begin
                    phase_q = P_EXT_LF;
                end
            end
            P_EXT_LF:
            begin
                if (r.in_byte == CH_LF) begin
                    phase_q = (chunk_left == '0) ? P_DONE : P_DATA;
                end
                else if (r.in_byte != CH_CR) begin
                    phase_q = P_EXT;
                end
            end
            P_DATA:
            begin
                o.out_valid = 1'b1;
                o.out_byte  = r.in_byte;
                chunk_left  = chunk_left - COUNT_BITS'(1);
                if (chunk_left == '0) begin
                    phase_q = P_DATA_CR;
                end
            end
            P_DATA_CR:
            begin
                phase_q = (r.in_byte == CH_CR) ? P_DATA_LF : P_ERR;
            end
            P_DATA_LF:
            begin
                phase_q = (r.in_byte == CH_LF) ? P_SIZE_FIRST : P_ERR;
            end
            P_DONE:
            begin
            end
            default:
            begin
                phase_q = P_ERR;
            end
        endcase
        if (r.last_byte && phase_q != P_DONE) begin
            phase_q = P_ERR;
        end
        if (phase_q == P_DONE) begin
            o.status = ST_DONE;
        end
        else if (phase_q == P_ERR) begin
            o.status = ST_ERR;
        end
        else begin
            o.status = ST_BUSY;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        req_t taken;
        if (rst_n) begin
            if (result.valid && result.ready) begin
                got.out_byte  = result.out_byte;
                got.out_valid = result.out_valid;
                got.status    = result.status;
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result %p with no request pending", got));
                end
                else begin
                    want = decoded_q.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  got.out_byte, want.out_byte));
                    end
                    if (got.out_valid !== want.out_valid) begin
                        report_mismatch($sformatf("out_valid %b, expected %b",
                                                  got.out_valid, want.out_valid));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    end
                end
            end
            if (body.valid && body.ready) begin
                taken.in_byte    = body.in_byte;
                taken.first_byte = body.first_byte;
                taken.last_byte  = body.last_byte;
                decoded_q.insert(decoded_q.size(), decode_byte(taken));
            end
        end
        fail_count    <= errors;
        expected_left <= decoded_q.size();
    end

endmodule

// ----- verif/http_chunked_body_decoder_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the chunked body decoder: builds directed and random chunked bodies,
// drives them with random gaps and result stalls, and gives the verdict.
// Depends on hcbd_pkg, hcbd_if, the decoder RTL and hcbd_decode_checker.
module http_chunked_body_decoder_test;
    import hcbd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 700;
    localparam int RUN_LIMIT    = 400000;
    localparam int TAIL_CYCLES  = 8;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic sink_ready = 1'b0;
    int   fail_count;
    int   expected_left;
    int   cycles     = 0;
    int   stall_left = 0;
    int   ready_calm = 0;
    req_t byte_plan[$];

    hcbd_body_if   body_ch();
    hcbd_result_if result_ch();

    assign result_ch.ready = sink_ready;

    http_chunked_body_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_ch),
        .result (result_ch)
    );

    hcbd_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .body          (body_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    task automatic push_byte(input logic [7:0] c, input logic first);
        req_t r;
        r.in_byte    = c;
        r.first_byte = first;
        r.last_byte  = 1'b0;
        byte_plan.insert(byte_plan.size(), r);
    endtask

    task automatic push_text(input string s, input logic first);
        for (int j = 0; j < s.len(); j++) begin
            push_byte(s[j], first && j == 0);
        end
    endtask

    task automatic push_crlf();
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
    endtask

    task automatic mark_last();
        req_t r;
        r = byte_plan[byte_plan.size() - 1];
        r.last_byte = 1'b1;
        byte_plan[byte_plan.size() - 1] = r;
    endtask

    task automatic push_size_line(input int unsigned size);
        string      digits;
        logic [7:0] c;
        logic [7:0] prev;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) push_byte(8'h30, 1'b0);
        end
        digits = $sformatf("%0h", size);
        for (int j = 0; j < digits.len(); j++) begin
            c = digits[j];
            if (c >= 8'h61 && $urandom_range(0, 1) == 1) begin
                c = c - 8'h20;
            end
            push_byte(c, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) begin
            push_byte(CH_SEMI, 1'b0);
            prev = CH_SEMI;
            repeat ($urandom_range(0, 5)) begin
                c = ($urandom_range(0, 3) == 0) ? CH_CR : 8'($urandom_range(0, 255));
                if (prev == CH_CR && c == CH_LF) begin
                    c = 8'h78;
                end
                push_byte(c, 1'b0);
                prev = c;
            end
        end
        push_crlf();
    endtask

    task automatic add_message();
        int   start;
        int   size;
        int   idx;
        req_t r;
        start = byte_plan.size();
        repeat ($urandom_range(0, 3)) begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            push_size_line(size);
            repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
            push_crlf();
        end
        push_size_line(0);
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 9) != 0) begin
            mark_last();
        end
        if ($urandom_range(0, 9) != 0) begin
            r = byte_plan[start];
            r.first_byte = 1'b1;
            byte_plan[start] = r;
        end
        if ($urandom_range(0, 99) < 25) begin
            idx = $urandom_range(start, byte_plan.size() - 1);
            case ($urandom_range(0, 2))
                0:
                begin
                    r = byte_plan[idx];
                    r.in_byte = 8'($urandom_range(0, 255));
                    byte_plan[idx] = r;
                end
                1:
                begin
                    while (byte_plan.size() > idx + 1) begin
                        void'(byte_plan.pop_back());
                    end
                    mark_last();
                end
                default:
                begin
                    r = byte_plan[idx];
                    r.first_byte = 1'b1;
                    byte_plan[idx] = r;
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end
        else if (ready_calm > 0) begin
            ready_calm--;
            sink_ready <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 2) begin
            ready_calm = $urandom_range(100, 300);
            sink_ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left--;
            sink_ready <= 1'b0;
        end
        else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                sink_ready <= 1'b0;
            end
            else begin
                sink_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int   directed;
        int   gap;
        int   send_calm;
        int   roll;
        int   digits;
        req_t r;
        send_calm = 0;
        body_ch.valid      <= 1'b0;
        body_ch.in_byte    <= 8'h00;
        body_ch.first_byte <= 1'b0;
        body_ch.last_byte  <= 1'b0;

        // zero chunk whose extension holds a bare CR, then a byte after completion
        push_text("0;", 1'b1);
        push_byte(CH_CR, 1'b0);
        push_text("a", 1'b0);
        push_crlf();
        push_byte(8'h00, 1'b0);
        mark_last();
        // data byte followed by a missing CRLF
        push_text("1", 1'b1);
        push_crlf();
        push_byte(8'hFF, 1'b0);
        push_text("x", 1'b0);
        // non-hex first digit
        push_text("G", 1'b1);
        // bare CR inside the size
        push_text("aF", 1'b1);
        push_byte(CH_CR, 1'b0);
        push_text("x", 1'b0);
        // body truncated on a data byte
        push_text("1", 1'b1);
        push_crlf();
        push_byte(8'h00, 1'b0);
        mark_last();
        // size overflow
        push_text("100000000", 1'b1);
        directed = byte_plan.size();

        while (byte_plan.size() < directed + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                add_message();
            end
            else if (roll < 88) begin
                digits = $urandom_range(8, 9);
                push_byte(($urandom_range(0, 1) == 1) ? 8'h46 : 8'h66, 1'b1);
                repeat (digits - 1) push_byte(8'h46, 1'b0);
                push_crlf();
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
                mark_last();
            end
            else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 5))
                        0:       r.in_byte = CH_CR;
                        1:       r.in_byte = CH_LF;
                        2:       r.in_byte = CH_SEMI;
                        3:       r.in_byte = 8'h30 + 8'($urandom_range(0, 9));
                        default: r.in_byte = 8'($urandom_range(0, 255));
                    endcase
                    r.first_byte = ($urandom_range(0, 3) == 0);
                    r.last_byte  = ($urandom_range(0, 4) == 0);
                    byte_plan.insert(byte_plan.size(), r);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < byte_plan.size(); i++) begin
            if (i == byte_plan.size() / 2) begin
                body_ch.valid <= 1'b0;
                @(posedge clk);
                while (expected_left != 0) @(posedge clk);
            end
            if (send_calm > 0) begin
                send_calm--;
                gap = 0;
            end
            else if ($urandom_range(0, 99) < 2) begin
                send_calm = $urandom_range(50, 150);
                gap = 0;
            end
            else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                body_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            body_ch.valid      <= 1'b1;
            body_ch.in_byte    <= byte_plan[i].in_byte;
            body_ch.first_byte <= byte_plan[i].first_byte;
            body_ch.last_byte  <= byte_plan[i].last_byte;
            do @(posedge clk); while (!body_ch.ready);
        end
        body_ch.valid <= 1'b0;

        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end
        else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/hcbd_pkg.sv
design/hcbd_if.sv
design/hcbd_parser.sv
design/hcbd_out_buf.sv
design/http_chunked_body_decoder.sv
design/hcbd_checker.sv
verif/hcbd_decode_checker.sv
verif/http_chunked_body_decoder_test.sv
